[design/pras_pkg.sv]
package pras_pkg;

    localparam int LEAVES = 1024;
    localparam int LOG_P  = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int P      = 1 << LOG_P;
    localparam int NODES  = 2 * P;
    localparam int NODE_W = LOG_P + 1;
    localparam int LVL_W  = $clog2(LOG_P + 1);
    localparam int LO_W   = 10;
    localparam int HI_W   = 11;
    localparam int CMP_W  = (LOG_P + 2 > HI_W) ? LOG_P + 2 : HI_W;
    localparam int TOT_W  = 64;
    localparam int STP_W  = 32;
    localparam int VAL_W  = 32;
    localparam int TRI_W  = 2 * LOG_P + 1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_SUM  = 2'd2;

    typedef struct packed {
        logic [TOT_W-1:0] tot;
        logic [TOT_W-1:0] off;
        logic [STP_W-1:0] stp;
    } node_t;

    localparam int WORD_W = $bits(node_t);

    typedef enum logic [1:0] {
        RD_NODE,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_LOAD,
        WR_NODE,
        WR_LEFT,
        WR_RIGHT,
        WR_SUM
    } wr_sel_t;

    typedef enum logic [2:0] {
        MV_HOLD,
        MV_DOWN,
        MV_NEXT,
        MV_UP,
        MV_LOAD_UP
    } mv_t;

    typedef struct packed {
        logic    start_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        mv_t     mv;
        logic    cap_node;
        logic    cap_left;
        logic    fold;
        logic    acc_add;
        logic    clr_step;
        logic    emit;
    } ctrl_t;

    typedef struct packed {
        logic       clear_done;
        logic       is_leaf;
        logic       covered;
        logic       disjoint;
        logic       is_left;
        logic       at_root;
        logic       load_ok;
        logic [1:0] cmd;
    } stat_t;

endpackage

[design/pras_ram.sv]
module pras_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pras_datapath.sv]
module pras_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pras_pkg::ctrl_t                   ctrl,
    output pras_pkg::stat_t                   stat,
    input  logic [1:0]                        command,
    input  logic [pras_pkg::LO_W-1:0]         lo,
    input  logic [pras_pkg::HI_W-1:0]         hi,
    input  logic signed [pras_pkg::VAL_W-1:0] value,
    output logic signed [pras_pkg::TOT_W-1:0] range_sum,
    output logic                              sum_valid
);

    logic [1:0]                      cmd_reg;
    logic [pras_pkg::CMP_W-1:0]      lo_reg;
    logic [pras_pkg::CMP_W-1:0]      hi_reg;
    logic [pras_pkg::TOT_W-1:0]      val_reg;
    logic [pras_pkg::NODE_W-1:0]     k_reg;
    logic [pras_pkg::LVL_W-1:0]      lvl_reg;
    logic [pras_pkg::NODE_W-1:0]     clr_reg;
    pras_pkg::node_t                 node_reg;
    logic [pras_pkg::TOT_W-1:0]      prod_reg;
    logic [pras_pkg::TOT_W-1:0]      left_tot_reg;
    logic [pras_pkg::TOT_W-1:0]      acc_reg;
    logic [pras_pkg::TOT_W-1:0]      range_sum_reg;
    logic                            sum_valid_reg;

    logic [pras_pkg::LVL_W-1:0]             shift;
    logic [pras_pkg::NODE_W-1:0]            lvl_mask;
    logic [pras_pkg::CMP_W-1:0]             x;
    logic [pras_pkg::CMP_W-1:0]             y;
    logic [pras_pkg::TRI_W-1:0]             tri_cnt;
    logic [pras_pkg::STP_W+pras_pkg::TRI_W-1:0] prod_full;
    logic                                   covered;
    logic                                   disjoint;
    logic                                   adj;
    pras_pkg::node_t                        rd;
    pras_pkg::node_t                        wdata;
    logic [pras_pkg::WORD_W-1:0]            rdata;
    logic [pras_pkg::NODE_W-1:0]            waddr;
    logic [pras_pkg::NODE_W-1:0]            raddr;
    logic                                   we;
    logic [pras_pkg::TOT_W-1:0]             fold_tot;
    logic [pras_pkg::TOT_W-1:0]             half_off;
    logic [pras_pkg::NODE_W-1:0]            left_k;

    assign shift    = pras_pkg::LVL_W'(pras_pkg::LOG_P) - lvl_reg;
    assign lvl_mask = (pras_pkg::NODE_W'(1) << lvl_reg) - pras_pkg::NODE_W'(1);
    assign x        = pras_pkg::CMP_W'(k_reg & lvl_mask) << shift;
    assign y        = x + (pras_pkg::CMP_W'(1) << shift);
    assign tri_cnt  = ((pras_pkg::TRI_W'(1) << {shift, 1'b0})
                      + (pras_pkg::TRI_W'(1) << shift)) >> 1;
    assign prod_full = node_reg.stp * tri_cnt;
    assign covered  = (lo_reg <= x) && (y <= hi_reg);
    assign disjoint = (hi_reg <= x) || (y <= lo_reg);
    assign adj      = (cmd_reg == pras_pkg::CMD_ADD) && covered;
    assign rd       = pras_pkg::node_t'(rdata);
    assign left_k   = {k_reg[pras_pkg::NODE_W-2:0], 1'b0};
    assign fold_tot = node_reg.tot + (node_reg.off << shift) + prod_reg;
    assign half_off = {{(pras_pkg::TOT_W-pras_pkg::STP_W){1'b0}}, node_reg.stp}
                      << (shift - pras_pkg::LVL_W'(1));

    always_comb
    begin
        case (ctrl.rd_sel)
            pras_pkg::RD_LEFT:  raddr = left_k;
            pras_pkg::RD_RIGHT: raddr = left_k | pras_pkg::NODE_W'(1);
            default:            raddr = k_reg;
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        waddr = k_reg;
        wdata = '0;
        case (ctrl.wr_sel)
            pras_pkg::WR_CLEAR:
            begin
                waddr = clr_reg;
            end
            pras_pkg::WR_LOAD:
            begin
                wdata     = rd;
                wdata.tot = rd.tot + val_reg;
            end
            pras_pkg::WR_NODE:
            begin
                wdata.tot = fold_tot;
            end
            pras_pkg::WR_LEFT:
            begin
                waddr     = left_k;
                wdata.tot = rd.tot;
                wdata.off = rd.off + node_reg.off;
                wdata.stp = rd.stp + node_reg.stp;
            end
            pras_pkg::WR_RIGHT:
            begin
                waddr     = left_k | pras_pkg::NODE_W'(1);
                wdata.tot = rd.tot;
                wdata.off = rd.off + node_reg.off + half_off;
                wdata.stp = rd.stp + node_reg.stp;
            end
            pras_pkg::WR_SUM:
            begin
                wdata.tot = left_tot_reg + rd.tot;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    pras_ram #(
        .WIDTH (pras_pkg::WORD_W),
        .DEPTH (pras_pkg::NODES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= pras_pkg::CMD_LOAD;
            k_reg         <= '0;
            lvl_reg       <= '0;
            clr_reg       <= '0;
            acc_reg       <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= ctrl.emit;
            if (ctrl.clr_step)
            begin
                clr_reg <= clr_reg + pras_pkg::NODE_W'(1);
            end
            if (ctrl.start_item)
            begin
                cmd_reg <= command;
                lvl_reg <= '0;
                acc_reg <= '0;
                if (command == pras_pkg::CMD_LOAD)
                begin
                    k_reg <= pras_pkg::NODE_W'(lo) + pras_pkg::NODE_W'(pras_pkg::P);
                end
                else
                begin
                    k_reg <= pras_pkg::NODE_W'(1);
                end
            end
            case (ctrl.mv)
                pras_pkg::MV_DOWN:
                begin
                    k_reg   <= left_k;
                    lvl_reg <= lvl_reg + pras_pkg::LVL_W'(1);
                end
                pras_pkg::MV_NEXT:
                begin
                    k_reg <= k_reg + pras_pkg::NODE_W'(1);
                end
                pras_pkg::MV_UP:
                begin
                    k_reg   <= k_reg >> 1;
                    lvl_reg <= lvl_reg - pras_pkg::LVL_W'(1);
                end
                pras_pkg::MV_LOAD_UP:
                begin
                    k_reg <= k_reg >> 1;
                end
                default:
                begin
                end
            endcase
            if (ctrl.acc_add)
            begin
                acc_reg <= acc_reg + node_reg.tot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= pras_pkg::TOT_W'(prod_full);
        if (ctrl.start_item)
        begin
            lo_reg  <= pras_pkg::CMP_W'(lo);
            hi_reg  <= pras_pkg::CMP_W'(hi);
            val_reg <= {{(pras_pkg::TOT_W-pras_pkg::VAL_W){value[pras_pkg::VAL_W-1]}}, value};
        end
        if (ctrl.cap_node)
        begin
            node_reg.tot <= rd.tot;
            node_reg.off <= adj ? rd.off + pras_pkg::TOT_W'(x - lo_reg) : rd.off;
            node_reg.stp <= adj ? rd.stp + pras_pkg::STP_W'(1) : rd.stp;
        end
        else if (ctrl.fold)
        begin
            node_reg.tot <= fold_tot;
        end
        if (ctrl.cap_left)
        begin
            left_tot_reg <= rd.tot;
        end
        if (ctrl.emit)
        begin
            range_sum_reg <= acc_reg;
        end
    end

    assign stat.clear_done = &clr_reg;
    assign stat.is_leaf    = k_reg[pras_pkg::NODE_W-1];
    assign stat.covered    = covered;
    assign stat.disjoint   = disjoint;
    assign stat.is_left    = ~k_reg[0];
    assign stat.at_root    = (k_reg == pras_pkg::NODE_W'(1));
    assign stat.load_ok    = pras_pkg::CMP_W'(lo) < pras_pkg::CMP_W'(pras_pkg::LEAVES);
    assign stat.cmd        = cmd_reg;

    assign range_sum = range_sum_reg;
    assign sum_valid = sum_valid_reg;

endmodule

[design/pras_ctrl.sv]
module pras_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      command,
    input  pras_pkg::stat_t stat,
    output pras_pkg::ctrl_t ctrl,
    output logic            busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_V_RD,
        S_V_CAP,
        S_V_MUL,
        S_V_FOLD,
        S_V_RDL,
        S_V_WRL,
        S_V_RDR,
        S_V_WRR,
        S_V_DEC,
        S_RET,
        S_F_RDL,
        S_F_RDR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fin_wr_reg;
    logic   fin_wr_next;

    always_comb
    begin
        ctrl        = '0;
        state_next  = state_reg;
        fin_wr_next = 1'b0;
        if (fin_wr_reg)
        begin
            ctrl.wr_sel = pras_pkg::WR_SUM;
        end
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.wr_sel   = pras_pkg::WR_CLEAR;
                ctrl.clr_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.start_item = 1'b1;
                    case (command)
                        pras_pkg::CMD_LOAD:
                        begin
                            if (stat.load_ok)
                            begin
                                state_next = S_LD_RD;
                            end
                        end
                        pras_pkg::CMD_ADD, pras_pkg::CMD_SUM:
                        begin
                            state_next = S_V_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LD_RD:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                ctrl.wr_sel = pras_pkg::WR_LOAD;
                ctrl.mv     = pras_pkg::MV_LOAD_UP;
                state_next  = stat.at_root ? S_IDLE : S_LD_RD;
            end
            S_V_RD:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_V_CAP;
            end
            S_V_CAP:
            begin
                ctrl.cap_node = 1'b1;
                state_next    = S_V_MUL;
            end
            S_V_MUL:
            begin
                state_next = S_V_FOLD;
            end
            S_V_FOLD:
            begin
                ctrl.wr_sel = pras_pkg::WR_NODE;
                ctrl.fold   = 1'b1;
                state_next  = stat.is_leaf ? S_V_DEC : S_V_RDL;
            end
            S_V_RDL:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = pras_pkg::RD_LEFT;
                state_next  = S_V_WRL;
            end
            S_V_WRL:
            begin
                ctrl.wr_sel = pras_pkg::WR_LEFT;
                state_next  = S_V_RDR;
            end
            S_V_RDR:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = pras_pkg::RD_RIGHT;
                state_next  = S_V_WRR;
            end
            S_V_WRR:
            begin
                ctrl.wr_sel = pras_pkg::WR_RIGHT;
                state_next  = S_V_DEC;
            end
            S_V_DEC:
            begin
                if (stat.covered)
                begin
                    ctrl.acc_add = (stat.cmd == pras_pkg::CMD_SUM);
                    state_next   = S_RET;
                end
                else if (stat.disjoint)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    ctrl.mv    = pras_pkg::MV_DOWN;
                    state_next = S_V_RD;
                end
            end
            S_RET:
            begin
                if (stat.at_root)
                begin
                    ctrl.emit  = (stat.cmd == pras_pkg::CMD_SUM);
                    state_next = S_IDLE;
                end
                else if (stat.is_left)
                begin
                    ctrl.mv    = pras_pkg::MV_NEXT;
                    state_next = S_V_RD;
                end
                else
                begin
                    ctrl.mv    = pras_pkg::MV_UP;
                    state_next = (stat.cmd == pras_pkg::CMD_ADD) ? S_F_RDL : S_RET;
                end
            end
            S_F_RDL:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = pras_pkg::RD_LEFT;
                state_next  = S_F_RDR;
            end
            S_F_RDR:
            begin
                ctrl.rd_en    = 1'b1;
                ctrl.rd_sel   = pras_pkg::RD_RIGHT;
                ctrl.cap_left = 1'b1;
                fin_wr_next   = 1'b1;
                state_next    = S_RET;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            fin_wr_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_wr_reg <= fin_wr_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/progression_range_add_sum_tree.sv]
// Lazy sum tree over 1024 signed positions: load, progression add and range
// sum commands. After reset the block sweeps the node memory with busy high.
// A command is taken when start is high and busy low; busy stays high until
// the walk ends. A load walks from the leaf up to the root, one tree level at
// a time; an add or sum walks the node memory, one port access a cycle, up to
// four nodes per level; a range covering the whole array visits only the root.
// A sum result appears on range_sum with sum_valid for exactly one cycle;
// the receiver cannot stall it and must take it in that cycle.
module progression_range_add_sum_tree (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [pras_pkg::LO_W-1:0]         lo,
    input  logic [pras_pkg::HI_W-1:0]         hi,
    input  logic signed [pras_pkg::VAL_W-1:0] value,
    output logic signed [pras_pkg::TOT_W-1:0] range_sum,
    output logic                              sum_valid
);

    pras_pkg::ctrl_t ctrl;
    pras_pkg::stat_t stat;

    pras_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    pras_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .command   (command),
        .lo        (lo),
        .hi        (hi),
        .value     (value),
        .range_sum (range_sum),
        .sum_valid (sum_valid)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        logic [1:0]                 cmd;
        logic [pras_pkg::LO_W-1:0]  lo;
        logic [pras_pkg::HI_W-1:0]  hi;
        logic [pras_pkg::VAL_W-1:0] val;
        bit                         fixed;
        logic [pras_pkg::TOT_W-1:0] sum;
    } row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         command;
    logic [pras_pkg::LO_W-1:0]          lo;
    logic [pras_pkg::HI_W-1:0]          hi;
    logic signed [pras_pkg::VAL_W-1:0]  value;
    logic signed [pras_pkg::TOT_W-1:0]  range_sum;
    logic                               sum_valid;

    logic [pras_pkg::TOT_W-1:0] position_total [pras_pkg::P];
    logic [pras_pkg::TOT_W-1:0] pending_sums [$];
    int                         mismatches;
    int                         cycles;
    int                         burst_left;
    row_t                       rows [$];

    progression_range_add_sum_tree dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .lo(lo),
        .hi(hi),
        .value(value),
        .range_sum(range_sum),
        .sum_valid(sum_valid)
    );

    always #2 clk = ~clk;

    function automatic logic [pras_pkg::TOT_W-1:0] sum_over(int a, int b);
        logic [pras_pkg::TOT_W-1:0] acc;
        acc = '0;
        for (int i = a; i < b && i < pras_pkg::P; i++)
            acc += position_total[i];
        return acc;
    endfunction

    // apply one command to the position array; return 1 with the sum for a query
    function automatic bit apply_command(logic [1:0] c, int a, int b,
                                         logic [pras_pkg::VAL_W-1:0] v,
                                         output logic [pras_pkg::TOT_W-1:0] s);
        s = '0;
        case (c)
            pras_pkg::CMD_LOAD:
            begin
                if (a < pras_pkg::LEAVES)
                    position_total[a] +=
                        {{(pras_pkg::TOT_W-pras_pkg::VAL_W){v[pras_pkg::VAL_W-1]}}, v};
                return 0;
            end
            pras_pkg::CMD_ADD:
            begin
                for (int i = a; i < b && i < pras_pkg::P; i++)
                    position_total[i] += pras_pkg::TOT_W'(i - a + 1);
                return 0;
            end
            pras_pkg::CMD_SUM:
            begin
                s = sum_over(a, b);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // hold start until a transfer, then at the end of a burst mostly idle for a random gap
    task automatic issue(row_t r);
        logic [pras_pkg::TOT_W-1:0] s;
        command <= r.cmd;
        lo <= r.lo;
        hi <= r.hi;
        value <= r.val;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (apply_command(r.cmd, int'(r.lo), int'(r.hi), r.val, s))
            pending_sums.push_back(r.fixed ? r.sum : s);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    endtask

    task automatic add_row(logic [1:0] c, int a, int b, logic [pras_pkg::VAL_W-1:0] v,
                           bit f = 0, logic [pras_pkg::TOT_W-1:0] s = '0);
        row_t r;
        r.cmd = c;
        r.lo = pras_pkg::LO_W'(a);
        r.hi = pras_pkg::HI_W'(b);
        r.val = v;
        r.fixed = f;
        r.sum = s;
        rows.push_back(r);
    endtask

    function automatic row_t random_item();
        row_t r;
        int k;
        int w;
        k = $urandom_range(0, 99);
        r.fixed = 0;
        r.sum = '0;
        r.val = $urandom();
        if ($urandom_range(0, 7) == 0)
            r.val = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        r.lo = pras_pkg::LO_W'($urandom());
        if ($urandom_range(0, 9) == 0)
        begin
            r.hi = pras_pkg::HI_W'($urandom());
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            w = $urandom_range(1, 8);
            r.hi = (int'(r.lo) + w > 1024) ? 11'd1024 : pras_pkg::HI_W'(int'(r.lo) + w);
        end
        else
        begin
            r.hi = pras_pkg::HI_W'($urandom_range(int'(r.lo) + 1, 1024));
        end
        if (k < 25)
            r.cmd = pras_pkg::CMD_LOAD;
        else if (k < 55)
            r.cmd = pras_pkg::CMD_ADD;
        else if (k < 97)
            r.cmd = pras_pkg::CMD_SUM;
        else
            r.cmd = CMD_NONE;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (sum_valid)
        begin
            if (pending_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected range_sum %h", range_sum);
            end
            else
            begin
                if (range_sum !== pending_sums[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range_sum expected %h got %h", pending_sums[0], range_sum);
                end
                void'(pending_sums.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int drain;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_NONE;
        lo = '0;
        hi = '0;
        value = '0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        foreach (position_total[i])
            position_total[i] = '0;

        add_row(pras_pkg::CMD_SUM, 0, 1024, 0, 1, 64'd0);
        add_row(pras_pkg::CMD_SUM, 500, 500, 0, 1, 64'd0);
        add_row(pras_pkg::CMD_SUM, 700, 3, 0, 1, 64'd0);
        add_row(pras_pkg::CMD_LOAD, 0, 1, 32'h7fff_ffff);
        add_row(pras_pkg::CMD_LOAD, 1023, 1, 32'h8000_0000);
        add_row(pras_pkg::CMD_LOAD, 512, 2047, 32'hffff_ffff);
        add_row(pras_pkg::CMD_SUM, 0, 1, 0, 1, 64'h0000_0000_7fff_ffff);
        add_row(pras_pkg::CMD_SUM, 1023, 1024, 0, 1, 64'hffff_ffff_8000_0000);
        add_row(CMD_NONE, 5, 9, 32'h1234_5678);
        add_row(pras_pkg::CMD_ADD, 0, 1024, 0);
        add_row(pras_pkg::CMD_SUM, 0, 1024, 0);
        add_row(pras_pkg::CMD_ADD, 1000, 2047, 32'hffff_ffff);
        add_row(pras_pkg::CMD_ADD, 300, 300, 0);
        add_row(pras_pkg::CMD_ADD, 600, 100, 0);
        add_row(pras_pkg::CMD_SUM, 1000, 2047, 0);
        add_row(pras_pkg::CMD_ADD, 3, 4, 0);
        add_row(pras_pkg::CMD_LOAD, 100, 1, 32'h0000_0005);
        add_row(pras_pkg::CMD_SUM, 0, 512, 0);
        add_row(pras_pkg::CMD_SUM, 511, 513, 0);
        add_row(pras_pkg::CMD_SUM, 1023, 2047, 0);
        add_row(pras_pkg::CMD_SUM, 2, 5, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            issue(rows[i]);

        for (int n = 0; n < 1600; n++)
        begin
            if (n == 800)
            begin
                start <= 1'b0;
                wait (pending_sums.size() == 0);
                @(posedge clk);
            end
            issue(random_item());
        end
        start <= 1'b0;

        wait (pending_sums.size() == 0);
        drain = 0;
        while (drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end

        if (mismatches == 0 && pending_sums.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
